// ===== design/chip8_instruction_step_top_defines.svh =====
// Assertion macros for the CHIP-8 instruction step block.
// Depends on nothing; included by the top level.
`ifndef CHIP8_INSTRUCTION_STEP_TOP_DEFINES_SVH
`define CHIP8_INSTRUCTION_STEP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define C8_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define C8_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C8_ASSERT(lbl, clk, rst, prop, msg)
`define C8_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== design/c8step_pkg.sv =====
// Package for the CHIP-8 instruction step block: payload types, codes, states.
// Depends on nothing.
package c8step_pkg;
   localparam int AddrW = 12;
   localparam logic [11:0] StartPc = 12'h200;
   localparam logic [15:0] InsCls = 16'h00E0;
   localparam logic [15:0] InsRet = 16'h00EE;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0, OP_EXEC = 2'd1, OP_RDREG = 2'd2, OP_RDPIX = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [11:0] addr;
      logic [7:0]  wdata;
   } req_type;

   typedef struct packed {
      logic [11:0] prog_counter;
      logic [7:0]  rdata;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE, ST_REG_Y,
      ST_EXEC, ST_SPR_ROW, ST_SPR_DATA, ST_PIX_RD, ST_PIX_WR, ST_CLS, ST_RESP
   } state_type;
endpackage

// ===== design/chip8_instruction_step_top.sv =====
// Top level of the CHIP-8 instruction step block: sequencer, memories, output stage.
// Depends on c8step_pkg and chip8_instruction_step_top_defines.svh.
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/ready    c8step_pkg::req_type
//   rsp_      out        rsp_valid/ready    c8step_pkg::rsp_type
//
// Writes and register reads answer straight from the idle state; pixel reads
// pass through ST_RESP. An instruction fetches its high and low bytes from
// program memory, then decodes, reads the register file and executes. A draw
// visits each sprite row: it fetches the row byte and scans its bits, with a
// framebuffer read-modify-write per lit sprite bit, and writes VF to finish.
// Clear screen sweeps the framebuffer. After reset, a clearing pass sweeps
// program memory and the framebuffer before the first transaction is accepted.
// The result sits in an output register; a stalled result blocks the next item.
`include "chip8_instruction_step_top_defines.svh"
module chip8_instruction_step_top #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  c8step_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output c8step_pkg::rsp_type rsp_data
);
   import c8step_pkg::*;
   localparam int SpW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Program memory and framebuffer: synchronous single-port memories.
   logic [7:0] mem_array [4096];
   logic       fb_array [2048];
   logic [7:0] regs_ff [16];
   logic [11:0] stack_ff [STACK_DEPTH];

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [11:0] pc_ff, pc_in, idx_ff, idx_in;
   logic [SpW-1:0] sp_ff, sp_in;
   logic [15:0] ins_ff, ins_in;
   logic [11:0] cnt_ff, cnt_in;      // clear sweep / pixel counter
   logic [3:0]  row_ff, row_in;
   logic [2:0]  col_ff, col_in;
   logic [7:0]  bits_ff, bits_in;
   logic [7:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic        hit_ff, hit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // Memory port controls.
   logic        mem_we;
   logic [11:0] mem_addr;
   logic [7:0]  mem_wd, mem_rd_ff;
   logic        fb_we, fb_wd, fb_rd_ff;
   logic [10:0] fb_addr;
   logic        reg_we;
   logic [3:0]  reg_wa;
   logic [7:0]  reg_wd;
   logic        vf_we;
   logic [7:0]  vf_wd;
   logic        stk_we;
   logic [11:0] stk_wd;

   logic [3:0] ins_x, ins_y, ins_n;
   logic [7:0] ins_kk;
   logic [8:0] sum9;
   logic [5:0] px;
   logic [4:0] py;

   always_ff @(posedge clock) begin
      if (mem_we) mem_array[mem_addr] <= mem_wd;
      mem_rd_ff <= mem_array[mem_addr];
      if (fb_we) fb_array[fb_addr] <= fb_wd;
      fb_rd_ff <= fb_array[fb_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) regs_ff[i] <= 8'd0;
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= 12'd0;
      end else begin
         if (reg_we) regs_ff[reg_wa] <= reg_wd;
         if (vf_we) regs_ff[15] <= vf_wd;
         if (stk_we) stack_ff[sp_ff] <= stk_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pc_ff <= StartPc;
         idx_ff <= 12'd0;
         sp_ff <= '0;
         cnt_ff <= 12'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         idx_ff <= idx_in;
         sp_ff <= sp_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      ins_ff <= ins_in;
      row_ff <= row_in;
      col_ff <= col_in;
      bits_ff <= bits_in;
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

   assign ins_x  = ins_ff[11:8];
   assign ins_y  = ins_ff[7:4];
   assign ins_n  = ins_ff[3:0];
   assign ins_kk = ins_ff[7:0];
   assign sum9   = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign px     = vx_ff[5:0] + {3'd0, col_ff};
   assign py     = vy_ff[4:0] + {1'b0, row_ff};

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      pc_in = pc_ff;
      idx_in = idx_ff;
      sp_in = sp_ff;
      ins_in = ins_ff;
      cnt_in = cnt_ff;
      row_in = row_ff;
      col_in = col_ff;
      bits_in = bits_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      hit_in = hit_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready = 1'b0;
      mem_we = 1'b0;
      mem_addr = pc_ff;
      mem_wd = 8'd0;
      fb_we = 1'b0;
      fb_wd = 1'b0;
      fb_addr = {py, px};
      reg_we = 1'b0;
      reg_wa = ins_x;
      reg_wd = 8'd0;
      vf_we = 1'b0;
      vf_wd = 8'd0;
      stk_we = 1'b0;
      stk_wd = pc_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_addr = cnt_ff;
            fb_we = 1'b1;
            fb_addr = cnt_ff[10:0];
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff == 12'hFFF) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && req_ready) begin
               req_in = req_data;
               unique case (req_data.op)
                  OP_WRITE: begin
                     mem_we = 1'b1;
                     mem_addr = req_data.addr;
                     mem_wd = req_data.wdata;
                     rsp_in = '{prog_counter: pc_ff, rdata: 8'd0};
                     rsp_valid_in = 1'b1;
                  end
                  OP_EXEC: state_in = ST_FETCH_HI;
                  OP_RDREG: begin
                     rsp_in.prog_counter = pc_ff;
                     rsp_in.rdata = (req_data.addr[11:4] == 8'd0) ?
                                    regs_ff[req_data.addr[3:0]] : 8'd0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_RDPIX: begin
                     fb_addr = req_data.addr[10:0];
                     state_in = ST_RESP;
                  end
                  default: ;
               endcase
            end
         end
         ST_RESP: begin
            rsp_in.prog_counter = pc_ff;
            rsp_in.rdata = req_ff.addr[11] ? 8'd0 : {7'd0, fb_rd_ff};
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FETCH_HI: begin
            // The high byte was read at the accepting edge.
            ins_in[15:8] = mem_rd_ff;
            mem_addr = pc_ff + 12'd1;
            state_in = ST_FETCH_LO;
         end
         ST_FETCH_LO: begin
            ins_in[7:0] = mem_rd_ff;
            pc_in = pc_ff + 12'd2;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_REG_Y;
         end
         ST_REG_Y: begin
            vx_in = regs_ff[ins_x];
            vy_in = regs_ff[ins_y];
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in.rdata = 8'd0;
            rsp_in.prog_counter = pc_ff;
            unique case (ins_ff[15:12])
               4'h0: begin
                  if (ins_ff == InsCls) begin
                     cnt_in = 12'd0;
                     rsp_valid_in = 1'b0;
                     state_in = ST_CLS;
                  end else if (ins_ff == InsRet) begin
                     sp_in = (sp_ff == '0) ? SpW'(STACK_DEPTH - 1) : sp_ff - 1'b1;
                     pc_in = stack_ff[sp_in];
                     rsp_in.prog_counter = pc_in;
                  end
               end
               4'h1: begin
                  pc_in = ins_ff[11:0];
                  rsp_in.prog_counter = pc_in;
               end
               4'h2: begin
                  stk_we = 1'b1;
                  sp_in = (sp_ff == SpW'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
                  pc_in = ins_ff[11:0];
                  rsp_in.prog_counter = pc_in;
               end
               4'h3: begin
                  if (vx_ff == ins_kk) begin
                     pc_in = pc_ff + 12'd2;
                     rsp_in.prog_counter = pc_in;
                  end
               end
               4'h6: begin
                  reg_we = 1'b1;
                  reg_wd = ins_kk;
               end
               4'h7: begin
                  reg_we = 1'b1;
                  reg_wd = vx_ff + ins_kk;
               end
               4'h8: begin
                  if (ins_n == 4'd0) begin
                     reg_we = 1'b1;
                     reg_wd = vy_ff;
                  end else if (ins_n == 4'd4) begin
                     reg_we = 1'b1;
                     reg_wd = sum9[7:0];
                     vf_we = 1'b1;
                     vf_wd = {7'd0, sum9[8]};
                  end
               end
               4'hA: idx_in = ins_ff[11:0];
               4'hD: begin
                  hit_in = 1'b0;
                  row_in = 4'd0;
                  rsp_valid_in = 1'b0;
                  state_in = ST_SPR_ROW;
               end
               default: ;
            endcase
         end
         ST_SPR_ROW: begin
            if (row_ff == ins_n) begin
               vf_we = 1'b1;
               vf_wd = {7'd0, hit_ff};
               rsp_in = '{prog_counter: pc_ff, rdata: 8'd0};
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               mem_addr = idx_ff + {8'd0, row_ff};
               state_in = ST_SPR_DATA;
            end
         end
         ST_SPR_DATA: begin
            bits_in = mem_rd_ff;
            col_in = 3'd0;
            state_in = ST_PIX_RD;
         end
         ST_PIX_RD: begin
            // Skip dark sprite bits; lit bits get a read-modify-write.
            if (bits_ff[7]) begin
               state_in = ST_PIX_WR;
            end else begin
               bits_in = {bits_ff[6:0], 1'b0};
               col_in = col_ff + 3'd1;
               if (col_ff == 3'd7) begin
                  row_in = row_ff + 4'd1;
                  state_in = ST_SPR_ROW;
               end
            end
         end
         ST_PIX_WR: begin
            fb_we = 1'b1;
            fb_wd = !fb_rd_ff;
            hit_in = hit_ff | fb_rd_ff;
            bits_in = {bits_ff[6:0], 1'b0};
            col_in = col_ff + 3'd1;
            if (col_ff == 3'd7) begin
               row_in = row_ff + 4'd1;
               state_in = ST_SPR_ROW;
            end else begin
               state_in = ST_PIX_RD;
            end
         end
         ST_CLS: begin
            fb_we = 1'b1;
            fb_addr = cnt_ff[10:0];
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff[10:0] == 11'h7FF) begin
               rsp_in = '{prog_counter: pc_ff, rdata: 8'd0};
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The input is never ready while a transaction is being worked on.
   `C8_ASSERT(a_no_accept_busy, clock, reset, (state_ff != ST_IDLE) |-> !req_ready, "busy")
   // A stalled result holds its payload.
   `C8_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "result dropped")
   // No item is accepted during the clearing pass.
   `C8_ASSERT_NR(a_clear_block, clock, (state_ff == ST_CLEAR) |-> !req_ready, "accept during clear")
endmodule
